// ===== rtl/mbs_pkg.sv =====
// Shared types and constants for the Modbus PDU responder.
package mbs_pkg;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_WEN  = 2'd1;
  localparam logic [1:0] OP_IREG = 2'd2;
  localparam logic [1:0] OP_DIN  = 2'd3;

  localparam logic [1:0] CFG_COIL  = 2'd0;
  localparam logic [1:0] CFG_DISC  = 2'd1;
  localparam logic [1:0] CFG_HOLD  = 2'd2;
  localparam logic [1:0] CFG_INREG = 2'd3;

  localparam logic [7:0] FC_RD_COILS = 8'h01;
  localparam logic [7:0] FC_RD_DISC  = 8'h02;
  localparam logic [7:0] FC_RD_HOLD  = 8'h03;
  localparam logic [7:0] FC_RD_INP   = 8'h04;
  localparam logic [7:0] FC_WR_COIL  = 8'h05;
  localparam logic [7:0] FC_WR_REG   = 8'h06;
  localparam logic [7:0] FC_DIAG_RD  = 8'h07;
  localparam logic [7:0] FC_WR_COILS = 8'h0F;
  localparam logic [7:0] FC_WR_REGS  = 8'h10;
  localparam logic [7:0] FC_REPORT   = 8'h11;
  localparam logic [7:0] FC_RW_REGS  = 8'h17;

  localparam logic [7:0] EXC_FLAG    = 8'h80;
  localparam logic [7:0] EXC_FUNC    = 8'd1;
  localparam logic [7:0] EXC_ADDR    = 8'd2;
  localparam logic [7:0] EXC_VALUE   = 8'd3;

  localparam logic [15:0] COIL_ON      = 16'hFF00;
  localparam logic [15:0] MAX_RD_BITS  = 16'd2000;
  localparam logic [15:0] MAX_WR_BITS  = 16'd1968;
  localparam logic [15:0] MAX_RD_REGS  = 16'd125;
  localparam logic [15:0] MAX_WR_REGS  = 16'd123;
  localparam logic [15:0] MAX_RW_REGS  = 16'd121;
  localparam logic [16:0] HDR_LEN      = 17'd10;
  localparam logic [16:0] WR_DATA_POS  = 17'd6;
  localparam logic [16:0] RW_DATA_POS  = 17'd10;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic        last;
    logic [7:0]  data;
    logic [10:0] idx;
    logic [15:0] val;
  } cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  bytes;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [11:0] coil;
    logic [11:0] disc;
    logic [8:0]  hold;
    logic [8:0]  inreg;
  } cnt_t;

  function automatic logic [16:0] clampc(logic [16:0] c, logic [16:0] d);
    return (c > d) ? d : c;
  endfunction

endpackage

// ===== rtl/mbs_fifo.sv =====
// Small synchronous queue with push/full and pop/empty.
module mbs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end
endmodule

// ===== rtl/mbs_front.sv =====
// Input side: accepts transactions, drops out-of-range loads, builds commands.
module mbs_front import mbs_pkg::*; #(
  parameter int BIT_DEPTH = 2048,
  parameter int REG_DEPTH = 256
) (
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_req_byte,
  input  logic        in_req_last,
  input  logic [10:0] in_load_index,
  input  logic [15:0] in_load_value,
  input  logic        busy,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);
  logic [16:0] idx17;
  logic        keep;

  assign idx17   = {6'd0, in_load_index};
  assign in_full = q_full || busy;

  always_comb begin
    case (in_op)
      OP_BYTE: keep = 1'b1;
      OP_WEN:  keep = idx17 < 17'(REG_DEPTH);
      OP_IREG: keep = idx17 < 17'(REG_DEPTH);
      OP_DIN:  keep = idx17 < 17'(BIT_DEPTH);
      default: keep = 1'b0;
    endcase
  end

  assign q_push      = in_push && !in_full && keep;
  assign q_data.op   = in_op;
  assign q_data.last = (in_op == OP_BYTE) && in_req_last;
  assign q_data.data = in_req_byte;
  assign q_data.idx  = in_load_index;
  assign q_data.val  = in_load_value;
endmodule

// ===== rtl/mbs_back.sv =====
// Execution side: request buffer, data tables, function decode and response packing.
module mbs_back import mbs_pkg::*; #(
  parameter int BIT_DEPTH = 2048,
  parameter int REG_DEPTH = 256,
  parameter int REQ_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  cnt_t cnt,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic clearing,
  input  logic out_full,
  output logic rsp_push,
  output rsp_t rsp
);
  localparam int BAW  = $clog2(BIT_DEPTH);
  localparam int RAW  = $clog2(REG_DEPTH);
  localparam int QAW  = $clog2(REQ_DEPTH);
  localparam int FW   = $clog2(REQ_DEPTH + 1);
  localparam int MAXD = (BIT_DEPTH > REG_DEPTH) ? BIT_DEPTH : REG_DEPTH;
  localparam logic [16:0] BIT17 = 17'(BIT_DEPTH);
  localparam logic [16:0] REG17 = 17'(REG_DEPTH);
  localparam logic [16:0] REQ17 = 17'(REQ_DEPTH);
  localparam logic [16:0] MAX17 = 17'(MAXD - 1);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DEC  = 4'd2;
  localparam logic [3:0] ST_W06  = 4'd3;
  localparam logic [3:0] ST_PRE  = 4'd4;
  localparam logic [3:0] ST_BITS = 4'd5;
  localparam logic [3:0] ST_REGS = 4'd6;
  localparam logic [3:0] ST_MW   = 4'd7;
  localparam logic [3:0] ST_MR   = 4'd8;

  logic         co_mem [BIT_DEPTH];
  logic         di_mem [BIT_DEPTH];
  logic [15:0]  hr_mem [REG_DEPTH];
  logic [15:0]  ir_mem [REG_DEPTH];
  logic         we_mem [REG_DEPTH];
  logic [7:0]   rq_mem [REQ_DEPTH];

  logic         co_we, co_wd, co_re, co_q;
  logic         di_we, di_wd, di_re, di_q;
  logic         hr_we, hr_re;
  logic [15:0]  hr_wd, hr_q;
  logic         ir_we, ir_re;
  logic [15:0]  ir_wd, ir_q;
  logic         we_we, we_wd, we_re, we_q;
  logic         rq_we, rq_re, rqv_r;
  logic [7:0]   rq_wd, rq_q, rq_val;
  logic [16:0]  co_wa, di_wa, hr_wa, ir_wa, we_wa, rq_wa;
  logic [16:0]  tb_ra, we_ra, rq_ra;

  logic [3:0]   st_r, st_nxt, nst_r, nst_nxt;
  logic [1:0]   ph_r, ph_nxt;
  logic [16:0]  clr_r, clr_nxt;
  logic [FW-1:0] fill_r, fill_nxt, len_r, len_nxt;
  logic [7:0]   hdr_r [10];
  logic [7:0]   hdr_nxt [10];
  logic [7:0]   pre_r [5];
  logic [7:0]   pre_nxt [5];
  logic [2:0]   pn_r, pn_nxt, pi_r, pi_nxt;
  logic         pend_r, pend_nxt, tsel_r, tsel_nxt;
  logic         m17_r, m17_nxt, usewe_r, usewe_nxt;
  logic [15:0]  i_r, i_nxt, lim_r, lim_nxt, a_r, a_nxt, q_r, q_nxt;
  logic [16:0]  idx_r, idx_nxt, j_r, j_nxt;
  logic [7:0]   acc_r, acc_nxt, hi_r, hi_nxt;
  logic [31:0]  pk_word_r, pk_word_nxt, word_n;
  logic [1:0]   pk_cnt_r, pk_cnt_nxt;
  logic         em_v, em_end;
  logic [7:0]   em_b;

  logic [7:0]   fc, wb;
  logic [15:0]  a, q, wa, wq, rv;
  logic [16:0]  aq, waq, cc, dc, hc, ic, qq7;
  logic         lastel, bitv, emitb, exc;
  logic [7:0]   exc_code, accn;

  assign rq_val   = rqv_r ? rq_q : 8'h00;
  assign clearing = (st_r == ST_CLR);

  assign fc  = hdr_r[0];
  assign a   = {hdr_r[1], hdr_r[2]};
  assign q   = {hdr_r[3], hdr_r[4]};
  assign wa  = {hdr_r[5], hdr_r[6]};
  assign wq  = {hdr_r[7], hdr_r[8]};
  assign wb  = hdr_r[9];
  assign aq  = {1'b0, a} + {1'b0, q};
  assign waq = {1'b0, wa} + {1'b0, wq};
  assign qq7 = {1'b0, q} + 17'd7;
  assign cc  = clampc({5'd0, cnt.coil}, BIT17);
  assign dc  = clampc({5'd0, cnt.disc}, BIT17);
  assign hc  = clampc({8'd0, cnt.hold}, REG17);
  assign ic  = clampc({8'd0, cnt.inreg}, REG17);
  assign lastel = (i_r == lim_r - 16'd1);
  assign rv  = tsel_r ? ir_q : hr_q;

  always_comb begin
    st_nxt = st_r; nst_nxt = nst_r; ph_nxt = ph_r; clr_nxt = clr_r;
    fill_nxt = fill_r; len_nxt = len_r; hdr_nxt = hdr_r; pre_nxt = pre_r;
    pn_nxt = pn_r; pi_nxt = pi_r; pend_nxt = pend_r; tsel_nxt = tsel_r;
    m17_nxt = m17_r; usewe_nxt = usewe_r; i_nxt = i_r; lim_nxt = lim_r;
    a_nxt = a_r; q_nxt = q_r; idx_nxt = idx_r; j_nxt = j_r;
    acc_nxt = acc_r; hi_nxt = hi_r;
    co_we = 1'b0; co_wa = idx_r; co_wd = 1'b0; co_re = 1'b0;
    di_we = 1'b0; di_wa = idx_r; di_wd = 1'b0; di_re = 1'b0;
    hr_we = 1'b0; hr_wa = idx_r; hr_wd = 16'd0; hr_re = 1'b0;
    ir_we = 1'b0; ir_wa = idx_r; ir_wd = 16'd0; ir_re = 1'b0;
    we_we = 1'b0; we_wa = idx_r; we_wd = 1'b0; we_re = 1'b0; we_ra = idx_r;
    rq_we = 1'b0; rq_wa = 17'(fill_r); rq_wd = cmd.data; rq_re = 1'b0; rq_ra = j_r;
    tb_ra = idx_r;
    cmd_pop = 1'b0;
    em_v = 1'b0; em_b = 8'd0; em_end = 1'b0;
    exc = 1'b0; exc_code = EXC_FUNC;
    bitv = tsel_r ? di_q : co_q;
    accn = acc_r | (8'(bitv) << i_r[2:0]);
    emitb = (i_r[2:0] == 3'd7) || lastel;

    case (st_r)
      ST_CLR: begin
        co_wa = clr_r; di_wa = clr_r; hr_wa = clr_r; ir_wa = clr_r; we_wa = clr_r;
        co_we = clr_r < BIT17;
        di_we = clr_r < BIT17;
        hr_we = clr_r < REG17;
        ir_we = clr_r < REG17;
        we_we = clr_r < REG17;
        clr_nxt = clr_r + 17'd1;
        if (clr_r == MAX17) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_WEN: begin
              we_we = 1'b1; we_wa = {6'd0, cmd.idx}; we_wd = cmd.val[0];
            end
            OP_IREG: begin
              ir_we = 1'b1; ir_wa = {6'd0, cmd.idx}; ir_wd = cmd.val;
            end
            OP_DIN: begin
              di_we = 1'b1; di_wa = {6'd0, cmd.idx}; di_wd = cmd.val[0];
            end
            default: begin
              if (17'(fill_r) < REQ17) begin
                rq_we = 1'b1;
                if (17'(fill_r) < HDR_LEN) hdr_nxt[fill_r[3:0]] = cmd.data;
                fill_nxt = fill_r + FW'(1);
              end
              if (cmd.last) st_nxt = ST_DEC;
            end
          endcase
        end
      end
      ST_DEC: begin
        len_nxt = fill_r;
        fill_nxt = '0;
        for (int k = 0; k < 10; k++) hdr_nxt[k] = 8'd0;
        pi_nxt = 3'd0; i_nxt = 16'd0; ph_nxt = 2'd0; acc_nxt = 8'd0;
        st_nxt = ST_PRE;
        pre_nxt[0] = hdr_r[0]; pre_nxt[1] = hdr_r[1]; pre_nxt[2] = hdr_r[2];
        pre_nxt[3] = hdr_r[3]; pre_nxt[4] = hdr_r[4];
        pn_nxt = 3'd5; pend_nxt = 1'b1; nst_nxt = ST_IDLE;
        idx_nxt = {1'b0, a}; lim_nxt = q; a_nxt = a; q_nxt = q;
        case (fc)
          FC_RD_COILS, FC_RD_DISC: begin
            if (q == 16'd0 || q > MAX_RD_BITS) begin
              exc = 1'b1; exc_code = EXC_VALUE;
            end else if (aq > ((fc == FC_RD_DISC) ? dc : cc)) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else begin
              pre_nxt[1] = qq7[10:3]; pn_nxt = 3'd2; pend_nxt = 1'b0;
              nst_nxt = ST_BITS; tsel_nxt = (fc == FC_RD_DISC);
            end
          end
          FC_RD_HOLD, FC_RD_INP: begin
            if (q == 16'd0 || q > MAX_RD_REGS) begin
              exc = 1'b1; exc_code = EXC_VALUE;
            end else if (aq > ((fc == FC_RD_INP) ? ic : hc)) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else begin
              pre_nxt[1] = {q[6:0], 1'b0}; pn_nxt = 3'd2; pend_nxt = 1'b0;
              nst_nxt = ST_REGS; tsel_nxt = (fc == FC_RD_INP);
            end
          end
          FC_WR_COIL: begin
            if ({1'b0, a} >= cc) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else if (q != COIL_ON && q != 16'd0) begin
              exc = 1'b1; exc_code = EXC_VALUE;
            end else begin
              co_we = 1'b1; co_wa = {1'b0, a}; co_wd = (q != 16'd0);
            end
          end
          FC_WR_REG: begin
            if ({1'b0, a} >= hc) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else begin
              we_re = 1'b1; we_ra = {1'b0, a}; st_nxt = ST_W06;
            end
          end
          FC_WR_COILS: begin
            if (q == 16'd0 || q > MAX_WR_BITS) begin
              exc = 1'b1; exc_code = EXC_VALUE;
            end else if (aq > cc) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else begin
              nst_nxt = ST_MW;
            end
          end
          FC_WR_REGS: begin
            if (q == 16'd0 || q > MAX_WR_REGS) begin
              exc = 1'b1; exc_code = EXC_VALUE;
            end else if (aq > hc) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else begin
              nst_nxt = ST_MR; usewe_nxt = 1'b1; m17_nxt = 1'b0; j_nxt = WR_DATA_POS;
            end
          end
          FC_RW_REGS: begin
            if (wq == 16'd0 || wq > MAX_RW_REGS || q == 16'd0 || q > MAX_RD_REGS ||
                {9'd0, wb} != {wq, 1'b0}) begin
              exc = 1'b1; exc_code = EXC_VALUE;
            end else if (aq > hc || waq > hc) begin
              exc = 1'b1; exc_code = EXC_ADDR;
            end else begin
              pre_nxt[1] = {q[6:0], 1'b0}; pn_nxt = 3'd2; pend_nxt = 1'b0;
              nst_nxt = ST_REGS; usewe_nxt = 1'b0; m17_nxt = 1'b1; tsel_nxt = 1'b0;
              idx_nxt = {1'b0, wa}; lim_nxt = wq; j_nxt = RW_DATA_POS;
              st_nxt = ST_MR;
            end
          end
          FC_DIAG_RD, FC_REPORT: st_nxt = ST_IDLE;
          default: begin
            exc = 1'b1; exc_code = EXC_FUNC;
          end
        endcase
        if (exc) begin
          pre_nxt[0] = fc + EXC_FLAG; pre_nxt[1] = exc_code;
          pn_nxt = 3'd2; pend_nxt = 1'b1; nst_nxt = ST_IDLE; st_nxt = ST_PRE;
        end
      end
      ST_W06: begin
        hr_wa = {1'b0, a_r}; hr_wd = q_r; hr_we = we_q;
        st_nxt = ST_PRE;
      end
      ST_PRE: begin
        if (!out_full) begin
          em_v = 1'b1; em_b = pre_r[pi_r];
          em_end = pend_r && (pi_r == pn_r - 3'd1);
          if (pi_r == pn_r - 3'd1) begin
            pi_nxt = 3'd0; st_nxt = nst_r;
          end else begin
            pi_nxt = pi_r + 3'd1;
          end
        end
      end
      ST_BITS: begin
        if (ph_r == 2'd0) begin
          co_re = 1'b1; di_re = 1'b1; ph_nxt = 2'd1;
        end else if (!(emitb && out_full)) begin
          em_v = emitb; em_b = accn; em_end = lastel;
          acc_nxt = emitb ? 8'd0 : accn;
          if (lastel) st_nxt = ST_IDLE;
          else begin
            i_nxt = i_r + 16'd1; idx_nxt = idx_r + 17'd1; ph_nxt = 2'd0;
          end
        end
      end
      ST_REGS: begin
        if (ph_r == 2'd0) begin
          hr_re = 1'b1; ir_re = 1'b1; ph_nxt = 2'd1;
        end else if (!out_full) begin
          em_v = 1'b1;
          if (ph_r == 2'd1) begin
            em_b = rv[15:8]; ph_nxt = 2'd2;
          end else begin
            em_b = rv[7:0]; em_end = lastel;
            if (lastel) st_nxt = ST_IDLE;
            else begin
              i_nxt = i_r + 16'd1; idx_nxt = idx_r + 17'd1; ph_nxt = 2'd0;
            end
          end
        end
      end
      ST_MW: begin
        if (ph_r == 2'd0) begin
          rq_re = 1'b1; rq_ra = 17'(i_r >> 3) + WR_DATA_POS; ph_nxt = 2'd1;
        end else begin
          co_we = 1'b1; co_wd = rq_val[i_r[2:0]];
          if (lastel) st_nxt = ST_IDLE;
          else begin
            i_nxt = i_r + 16'd1; idx_nxt = idx_r + 17'd1; ph_nxt = 2'd0;
          end
        end
      end
      ST_MR: begin
        if (ph_r == 2'd0) begin
          rq_re = 1'b1; we_re = 1'b1; ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          hi_nxt = rq_val; rq_re = 1'b1; rq_ra = j_r + 17'd1; ph_nxt = 2'd2;
        end else begin
          hr_we = !usewe_r || we_q; hr_wd = {hi_r, rq_val};
          ph_nxt = 2'd0;
          if (lastel) begin
            if (m17_r) begin
              st_nxt = ST_PRE; idx_nxt = {1'b0, a_r}; lim_nxt = q_r; i_nxt = 16'd0;
            end else begin
              st_nxt = ST_IDLE;
            end
          end else begin
            i_nxt = i_r + 16'd1; idx_nxt = idx_r + 17'd1; j_nxt = j_r + 17'd2;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    word_n = pk_word_r;
    word_n[{~pk_cnt_r, 3'b000} +: 8] = em_b;
    rsp_push = em_v && (em_end || pk_cnt_r == 2'd3);
    rsp.word = word_n;
    rsp.bytes = {1'b0, pk_cnt_r} + 3'd1;
    rsp.last = em_end;
    pk_word_nxt = pk_word_r;
    pk_cnt_nxt = pk_cnt_r;
    if (em_v) begin
      if (rsp_push) begin
        pk_word_nxt = 32'd0; pk_cnt_nxt = 2'd0;
      end else begin
        pk_word_nxt = word_n; pk_cnt_nxt = pk_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (co_we) co_mem[co_wa[BAW-1:0]] <= co_wd;
    if (co_re) co_q <= co_mem[tb_ra[BAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (di_we) di_mem[di_wa[BAW-1:0]] <= di_wd;
    if (di_re) di_q <= di_mem[tb_ra[BAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hr_we) hr_mem[hr_wa[RAW-1:0]] <= hr_wd;
    if (hr_re) hr_q <= hr_mem[tb_ra[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ir_we) ir_mem[ir_wa[RAW-1:0]] <= ir_wd;
    if (ir_re) ir_q <= ir_mem[tb_ra[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_we) we_mem[we_wa[RAW-1:0]] <= we_wd;
    if (we_re) we_q <= we_mem[we_ra[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rq_we) rq_mem[rq_wa[QAW-1:0]] <= rq_wd;
    if (rq_re) begin
      rq_q  <= rq_mem[rq_ra[QAW-1:0]];
      rqv_r <= rq_ra < 17'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLR;
      clr_r     <= 17'd0;
      fill_r    <= '0;
      pk_cnt_r  <= 2'd0;
      pk_word_r <= 32'd0;
      ph_r      <= 2'd0;
      pi_r      <= 3'd0;
      for (int k = 0; k < 10; k++) hdr_r[k] <= 8'd0;
    end else begin
      st_r      <= st_nxt;
      clr_r     <= clr_nxt;
      fill_r    <= fill_nxt;
      pk_cnt_r  <= pk_cnt_nxt;
      pk_word_r <= pk_word_nxt;
      ph_r      <= ph_nxt;
      pi_r      <= pi_nxt;
      hdr_r     <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nst_r <= nst_nxt; len_r <= len_nxt; pre_r <= pre_nxt; pn_r <= pn_nxt;
    pend_r <= pend_nxt; tsel_r <= tsel_nxt; m17_r <= m17_nxt; usewe_r <= usewe_nxt;
    i_r <= i_nxt; lim_r <= lim_nxt; a_r <= a_nxt; q_r <= q_nxt;
    idx_r <= idx_nxt; j_r <= j_nxt; acc_r <= acc_nxt; hi_r <= hi_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) rsp_push |-> !out_full)
    else $error("response word pushed into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n) (st_r == ST_CLR) |-> !cmd_pop)
    else $error("command taken during clearing pass");
  assert property (@(posedge clk) disable iff (!rst_n) (st_r == ST_DEC) |=> (fill_r == '0))
    else $error("request fill not dropped after decode");
  assert property (@(posedge clk) disable iff (!rst_n) 17'(fill_r) <= REQ17)
    else $error("request fill beyond buffer depth");
endmodule

// ===== rtl/modbus_slave_pdu_responder.sv =====
// Modbus slave PDU responder: request intake, execution engine and result queue.
// After reset the block runs a clearing pass over all tables, max(BIT_DEPTH, REG_DEPTH) addresses,
// with full held high; configuration writes are taken throughout. A request byte or a table
// load is taken through the command queue. Once the last request byte is in, the engine
// answers through its tables: a coil or discrete bit is read or written in a fetch step and
// an act step, a register in a fetch step, a high-byte step and a low-byte step, and the
// header bytes go out one at a time; response output stalls whenever the result queue is
// full.
module modbus_slave_pdu_responder import mbs_pkg::*; #(
  parameter int BIT_DEPTH = 2048,
  parameter int REG_DEPTH = 256,
  parameter int REQ_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_req_byte,
  input  logic        in_req_last,
  input  logic [10:0] in_load_index,
  input  logic [15:0] in_load_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_rsp_word,
  output logic [2:0]  out_rsp_bytes,
  output logic        out_rsp_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  cnt_t        cnt_r;
  cmd_t        f_cmd, b_cmd;
  rsp_t        b_rsp, o_rsp;
  logic        f_push, q_full, q_empty, b_pop, busy;
  logic        rsp_push, o_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r.coil  <= 12'd2048;
      cnt_r.disc  <= 12'd2048;
      cnt_r.hold  <= 9'd256;
      cnt_r.inreg <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COIL:  cnt_r.coil  <= cfg_data;
        CFG_DISC:  cnt_r.disc  <= cfg_data;
        CFG_HOLD:  cnt_r.hold  <= cfg_data[8:0];
        CFG_INREG: cnt_r.inreg <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  mbs_front #(.BIT_DEPTH(BIT_DEPTH), .REG_DEPTH(REG_DEPTH)) u_front (
    .in_push(in_push), .in_full(in_full), .in_op(in_op), .in_req_byte(in_req_byte),
    .in_req_last(in_req_last), .in_load_index(in_load_index),
    .in_load_value(in_load_value), .busy(busy), .q_full(q_full),
    .q_push(f_push), .q_data(f_cmd)
  );

  mbs_fifo #(.W($bits(cmd_t)), .DEPTH(Q_DEPTH)) u_cmdq (
    .clk(clk), .rst_n(rst_n), .push(f_push), .wdata(f_cmd), .full(q_full),
    .pop(b_pop), .rdata(b_cmd), .empty(q_empty)
  );

  mbs_back #(.BIT_DEPTH(BIT_DEPTH), .REG_DEPTH(REG_DEPTH), .REQ_DEPTH(REQ_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cnt(cnt_r), .cmd_valid(!q_empty), .cmd(b_cmd),
    .cmd_pop(b_pop), .clearing(busy), .out_full(o_full), .rsp_push(rsp_push),
    .rsp(b_rsp)
  );

  mbs_fifo #(.W($bits(rsp_t)), .DEPTH(Q_DEPTH)) u_rspq (
    .clk(clk), .rst_n(rst_n), .push(rsp_push), .wdata(b_rsp), .full(o_full),
    .pop(out_pop), .rdata(o_rsp), .empty(out_empty)
  );

  assign out_rsp_word  = o_rsp.word;
  assign out_rsp_bytes = o_rsp.bytes;
  assign out_rsp_last  = o_rsp.last;
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Modbus PDU responder: directed and random requests.
module testbench;
  import mbs_pkg::*;

  localparam int BITS = 2048;
  localparam int REGS = 256;
  localparam int REQN = 256;
  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_op;
  logic [7:0]  in_req_byte;
  logic        in_req_last;
  logic [10:0] in_load_index;
  logic [15:0] in_load_value;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_rsp_word;
  logic [2:0]  out_rsp_bytes;
  logic        out_rsp_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  modbus_slave_pdu_responder DUT (.*);

  // model state
  logic [11:0] m_coil_cnt, m_disc_cnt;
  logic [8:0]  m_hold_cnt, m_inreg_cnt;
  logic [7:0]  m_req [REQN];
  int          m_fill;
  logic        m_coil [BITS];
  logic        m_disc [BITS];
  logic [15:0] m_hold [REGS];
  logic [15:0] m_inreg [REGS];
  logic        m_wen [REGS];
  logic [7:0]  reply [$];

  rsp_t        pending_words [$];
  int          errors;
  int          idle_cycles;
  bit          quiet;
  bit          hold_off;
  int          hold_len;
  int          pop_gap;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rd8(int i);
    return (i < REQN) ? int'(m_req[i]) : 0;
  endfunction

  function automatic int rd16(int i);
    return (rd8(i) << 8) | rd8(i + 1);
  endfunction

  function automatic int clip(int c, int d);
    return (c > d) ? d : c;
  endfunction

  function automatic void reply_exc(int fc, logic [7:0] code);
    reply.delete();
    reply.push_back(8'(fc + int'(EXC_FLAG)));
    reply.push_back(code);
  endfunction

  function automatic void reply_bits(int fc, bit discrete, int cnt);
    int a, q, acc, sh;
    a = rd16(1);
    q = rd16(3);
    acc = 0;
    sh = 0;
    if (q < 1 || q > int'(MAX_RD_BITS)) begin
      reply_exc(fc, EXC_VALUE);
    end else if (a + q > clip(cnt, BITS)) begin
      reply_exc(fc, EXC_ADDR);
    end else begin
      reply.push_back(8'(fc));
      reply.push_back(8'((q + 7) / 8));
      for (int i = a; i < a + q; i++) begin
        acc |= int'(discrete ? m_disc[i] : m_coil[i]) << sh;
        if (sh == 7) begin
          reply.push_back(8'(acc));
          acc = 0;
          sh = 0;
        end else begin
          sh++;
        end
      end
      if (sh != 0) reply.push_back(8'(acc));
    end
  endfunction

  function automatic void reply_regs(int fc, bit inputs, int cnt);
    int a, q;
    logic [15:0] v;
    a = rd16(1);
    q = rd16(3);
    if (q < 1 || q > int'(MAX_RD_REGS)) begin
      reply_exc(fc, EXC_VALUE);
    end else if (a + q > clip(cnt, REGS)) begin
      reply_exc(fc, EXC_ADDR);
    end else begin
      reply.push_back(8'(fc));
      reply.push_back(8'(q * 2));
      for (int i = a; i < a + q; i++) begin
        v = inputs ? m_inreg[i] : m_hold[i];
        reply.push_back(v[15:8]);
        reply.push_back(v[7:0]);
      end
    end
  endfunction

  // returns 0 when the request gets no response
  function automatic bit execute_request();
    int fc, a, q, hc, wa, wq, wb, j;
    logic [15:0] v;
    fc = rd8(0);
    a = rd16(1);
    q = rd16(3);
    hc = clip(int'(m_hold_cnt), REGS);
    reply.delete();
    case (8'(fc))
      FC_RD_COILS: reply_bits(fc, 1'b0, int'(m_coil_cnt));
      FC_RD_DISC:  reply_bits(fc, 1'b1, int'(m_disc_cnt));
      FC_RD_HOLD:  reply_regs(fc, 1'b0, int'(m_hold_cnt));
      FC_RD_INP:   reply_regs(fc, 1'b1, int'(m_inreg_cnt));
      FC_WR_COIL: begin
        if (a >= clip(int'(m_coil_cnt), BITS)) reply_exc(fc, EXC_ADDR);
        else if (q != int'(COIL_ON) && q != 0) reply_exc(fc, EXC_VALUE);
        else begin
          m_coil[a] = (q != 0);
          for (int i = 0; i < 5; i++) reply.push_back(8'(rd8(i)));
        end
      end
      FC_WR_REG: begin
        if (a >= hc) reply_exc(fc, EXC_ADDR);
        else begin
          if (m_wen[a]) m_hold[a] = 16'(q);
          for (int i = 0; i < 5; i++) reply.push_back(8'(rd8(i)));
        end
      end
      FC_WR_COILS: begin
        if (q < 1 || q > int'(MAX_WR_BITS)) reply_exc(fc, EXC_VALUE);
        else if (a + q > clip(int'(m_coil_cnt), BITS)) reply_exc(fc, EXC_ADDR);
        else begin
          for (int i = 0; i < q; i++)
            m_coil[a + i] = 1'((rd8(6 + (i >> 3)) >> (i & 7)) & 1);
          for (int i = 0; i < 5; i++) reply.push_back(8'(rd8(i)));
        end
      end
      FC_WR_REGS: begin
        if (q < 1 || q > int'(MAX_WR_REGS)) reply_exc(fc, EXC_VALUE);
        else if (a + q > hc) reply_exc(fc, EXC_ADDR);
        else begin
          j = 6;
          for (int i = a; i < a + q; i++) begin
            if (m_wen[i]) m_hold[i] = 16'(rd16(j));
            j += 2;
          end
          for (int i = 0; i < 5; i++) reply.push_back(8'(rd8(i)));
        end
      end
      FC_RW_REGS: begin
        wa = rd16(5);
        wq = rd16(7);
        wb = rd8(9);
        if (wq < 1 || wq > int'(MAX_RW_REGS) || q < 1 || q > int'(MAX_RD_REGS) ||
            wb != wq * 2) reply_exc(fc, EXC_VALUE);
        else if (a + q > hc || wa + wq > hc) reply_exc(fc, EXC_ADDR);
        else begin
          j = 10;
          for (int i = wa; i < wa + wq; i++) begin
            m_hold[i] = 16'(rd16(j));
            j += 2;
          end
          reply.push_back(8'(fc));
          reply.push_back(8'(q * 2));
          for (int i = a; i < a + q; i++) begin
            v = m_hold[i];
            reply.push_back(v[15:8]);
            reply.push_back(v[7:0]);
          end
        end
      end
      FC_DIAG_RD, FC_REPORT: return 1'b0;
      default: reply_exc(fc, EXC_FUNC);
    endcase
    return 1'b1;
  endfunction

  task automatic predict_item(cmd_t c);
    rsp_t w;
    int n;
    bit answered;
    case (c.op)
      OP_WEN:  if (c.idx < REGS) m_wen[c.idx] = c.val[0];
      OP_IREG: if (c.idx < REGS) m_inreg[c.idx] = c.val;
      OP_DIN:  if (c.idx < BITS) m_disc[c.idx] = c.val[0];
      default: begin
        if (m_fill < REQN) begin
          m_req[m_fill] = c.data;
          m_fill++;
        end
        if (c.last) begin
          answered = execute_request();
          for (int i = 0; i < REQN; i++) m_req[i] = 8'h00;
          m_fill = 0;
          if (answered && reply.size() > 0) begin
            n = (reply.size() + 3) / 4;
            for (int k = 0; k < n; k++) begin
              w = '0;
              for (int b = 0; b < 4; b++) begin
                if (k * 4 + b < reply.size()) begin
                  w.word[31 - 8 * b -: 8] = reply[k * 4 + b];
                  w.bytes++;
                end
              end
              w.last = (k + 1 == n);
              pending_words.push_back(w);
            end
          end
        end
      end
    endcase
  endtask

  task automatic send_item(cmd_t c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_op         <= c.op;
    in_req_byte   <= c.data;
    in_req_last   <= c.last;
    in_load_index <= c.idx;
    in_load_value <= c.val;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_item(c);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    cmd_t c;
    c.op = OP_BYTE;
    c.data = b;
    c.last = last;
    c.idx = 11'($urandom);
    c.val = 16'($urandom);
    send_item(c);
  endtask

  task automatic send_load(logic [1:0] op, int idx, logic [15:0] val);
    cmd_t c;
    c.op = op;
    c.data = 8'($urandom);
    c.last = 1'($urandom);
    c.idx = 11'(idx);
    c.val = val;
    send_item(c);
  endtask

  task automatic send_request(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COIL:  m_coil_cnt = v;
      CFG_DISC:  m_disc_cnt = v;
      CFG_HOLD:  m_hold_cnt = v[8:0];
      default:   m_inreg_cnt = v[8:0];
    endcase
  endtask

  task automatic set_counts(int c, int d, int h, int r);
    write_reg(CFG_COIL, 12'(c));
    write_reg(CFG_DISC, 12'(d));
    write_reg(CFG_HOLD, 12'(h));
    write_reg(CFG_INREG, 12'(r));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    for (int i = 0; i < 4; i++) send_load(OP_WEN, i, 16'h0001);
    send_load(OP_WEN, 2047, 16'hFFFF);
    send_load(OP_IREG, 255, 16'hFFFF);
    send_load(OP_DIN, 2047, 16'h0001);
    send_load(OP_DIN, 0, 16'hFFFE);
    send_request('{FC_WR_COIL, 8'h07, 8'hFF, 8'hFF, 8'h00});
    send_request('{FC_WR_COIL, 8'h00, 8'h01, 8'h12, 8'h34});
    send_request('{FC_WR_REG, 8'h00, 8'h01, 8'hAB, 8'hCD});
    send_request('{FC_WR_REG, 8'h00, 8'h09, 8'hAB, 8'hCD});
    send_request('{FC_RD_COILS, 8'h07, 8'hF0, 8'h00, 8'h10});
    send_request('{FC_RD_DISC, 8'h00, 8'h00, 8'h07, 8'hD0});
    send_request('{FC_RD_INP, 8'h00, 8'hFF, 8'h00, 8'h01});
    send_request('{FC_RD_HOLD, 8'h00, 8'h00, 8'h00, 8'h00});
    send_request('{FC_WR_REGS, 8'h00, 8'h00, 8'h00, 8'h03, 8'h06, 8'h11, 8'h22});
    send_request('{FC_RW_REGS, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h02, 8'h00,
                   8'h01, 8'h02, 8'hBE, 8'hEF});
    send_request('{FC_WR_COILS, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h02, 8'hA5, 8'h03});
    send_request('{FC_DIAG_RD});
    send_request('{FC_REPORT, 8'h55});
    send_request('{8'hFF});
    send_request('{FC_RD_HOLD});
    drain();
  endtask

  task automatic random_request(output int nbytes);
    logic [7:0] q[$];
    int fc, a, n, wq, wa, r;
    r = $urandom_range(0, 11);
    fc = (r == 0) ? $urandom_range(0, 255) :
         (r < 10) ? int'(FC_RD_COILS) + r - 1 : int'(FC_RW_REGS);
    if (fc == 8) fc = int'(FC_WR_COILS);
    if (fc == 9) fc = int'(FC_WR_REGS);
    a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2100) : $urandom_range(1, 12);
    if (fc == int'(FC_WR_COIL))
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
          ($urandom_range(0, 1) ? int'(COIL_ON) : 0);
    if (fc == int'(FC_WR_REG)) n = $urandom_range(0, 65535);
    q.push_back(8'(fc));
    q.push_back(8'(a >> 8));
    q.push_back(8'(a));
    q.push_back(8'(n >> 8));
    q.push_back(8'(n));
    if (fc == int'(FC_RW_REGS)) begin
      wa = $urandom_range(0, 30);
      wq = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 130) : $urandom_range(1, 6);
      q.push_back(8'(wa >> 8));
      q.push_back(8'(wa));
      q.push_back(8'(wq >> 8));
      q.push_back(8'(wq));
      q.push_back(8'(($urandom_range(0, 7) == 0) ? $urandom : wq * 2));
      for (int i = 0; i < 2 * wq && i < 12; i++) q.push_back(8'($urandom));
    end else if (fc == int'(FC_WR_COILS) || fc == int'(FC_WR_REGS)) begin
      q.push_back(8'($urandom));
      for (int i = 0; i < $urandom_range(0, 10); i++) q.push_back(8'($urandom));
    end else if ($urandom_range(0, 5) == 0) begin
      q = q[0:$urandom_range(0, 4)];
    end
    nbytes = q.size();
    send_request(q);
  endtask

  task automatic random_load();
    int idx;
    idx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 40);
    send_load(2'($urandom_range(1, 3)), idx, 16'($urandom));
  endtask

  task automatic test_random(int items);
    int sent, nb;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 2) == 0) begin
        random_load();
        sent++;
      end else begin
        random_request(nb);
        sent += nb;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_len = 600;
    hold_off = 1'b1;
    for (int i = 0; i < 4; i++)
      send_request('{FC_RD_HOLD, 8'h00, 8'h00, 8'h00, 8'h7D});
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_off) begin
      out_pop <= 1'b0;
      if (hold_len > 0) hold_len <= hold_len - 1;
      else hold_off <= 1'b0;
    end else if (quiet) begin
      out_pop <= 1'b1;
    end else if (pop_gap > 0) begin
      out_pop <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_pop <= 1'b0;
      pop_gap <= $urandom_range(0, 4);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_words.size() == 0) begin
        $error("unexpected response word %h", out_rsp_word);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_rsp_word !== e.word) begin
          $error("rsp_word expected %h actual %h", e.word, out_rsp_word);
          errors++;
        end
        if (out_rsp_bytes !== e.bytes) begin
          $error("rsp_bytes expected %0d actual %0d", e.bytes, out_rsp_bytes);
          errors++;
        end
        if (out_rsp_last !== e.last) begin
          $error("rsp_last expected %0d actual %0d", e.last, out_rsp_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    hold_len = 0;
    pop_gap = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = OP_BYTE;
    in_req_byte = '0;
    in_req_last = 1'b0;
    in_load_index = '0;
    in_load_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COIL;
    cfg_data = '0;
    m_coil_cnt = 12'd2048;
    m_disc_cnt = 12'd2048;
    m_hold_cnt = 9'd256;
    m_inreg_cnt = 9'd256;
    m_fill = 0;
    for (int i = 0; i < BITS; i++) begin
      m_coil[i] = 1'b0;
      m_disc[i] = 1'b0;
    end
    for (int i = 0; i < REGS; i++) begin
      m_hold[i] = '0;
      m_inreg[i] = '0;
      m_wen[i] = 1'b0;
      m_req[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_counts(16, 0, 12, 0);
    test_random(50);
    set_counts(4095, 2000, 511, 100);
    test_random(50);
    set_counts(0, 4095, 0, 511);
    test_random(30);
    set_counts(2048, 2048, 256, 256);
    test_backpressure();
    test_random(50);
    quiet = 1'b1;
    test_random(30);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mbs_pkg.sv
rtl/mbs_fifo.sv
rtl/mbs_front.sv
rtl/mbs_back.sv
rtl/modbus_slave_pdu_responder.sv
tb/sv/testbench.sv
